// File: hdl/box_sum_and_square_sum_macros.svh
// ----------------------------------------------------------------------------
// box sum and square sum assertion macros
// Overlapping-implication and next-cycle property checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef BOX_SUM_AND_SQUARE_SUM_MACROS_SVH
`define BOX_SUM_AND_SQUARE_SUM_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BSSQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bssq check failed");
`define BSSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bssq check failed");
`else
`define BSSQ_ASSERT_IMPLIES(label, ante, cons)
`define BSSQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/bssq_pkg.sv
// ----------------------------------------------------------------------------
// bssq_pkg
// Shared sizes, register indexes, pipeline structs and a clamp helper of the
// sliding window box sum and square sum block.
// ----------------------------------------------------------------------------
package bssq_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_WINDOW = 31;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int WIN_W  = 5;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int CNT_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;

    localparam int ROWBUF_AW    = SLOT_W + COL_W;
    localparam int ROWBUF_DEPTH = 2 ** ROWBUF_AW;

    localparam int SQ_W     = 2 * PIX_W;
    localparam int CSUM_W   = 13;
    localparam int CSQ_W    = 21;
    localparam int SUM_W    = 18;
    localparam int SQS_W    = 26;
    localparam int COLMEM_W = CSUM_W + CSQ_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(1024);
    localparam logic [WIN_W-1:0] RST_WINDOW_SIZE  = WIN_W'(3);

    typedef struct packed {
        logic [PIX_W-1:0]     pixel;
        logic                 first_row;
        logic                 use_old;
        logic                 row_start;
        logic                 drop_left;
        logic                 result;
        logic [COL_W-1:0]     out_col;
        logic [ROW_W-1:0]     out_row;
        logic                 frame_end;
        logic [ROWBUF_AW-1:0] row_addr;
        logic [COL_W-1:0]     col_addr;
        logic [COL_W-1:0]     left_addr;
    } t_item;

    typedef struct packed {
        logic                 en;
        logic [ROWBUF_AW-1:0] row_addr;
        logic [PIX_W-1:0]     row_data;
        logic [COL_W-1:0]     col_addr;
        logic [COLMEM_W-1:0]  col_data;
    } t_wr;

    typedef struct packed {
        logic s1_v;
        logic s2_v;
    } t_pipe_stat;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

endpackage

// File: hdl/bssq_ram.sv
// ----------------------------------------------------------------------------
// bssq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bssq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/bssq_pos.sv
// ----------------------------------------------------------------------------
// bssq_pos
// Configuration registers and raster position tracking. Builds the request
// descriptor and the memory addresses for each incoming pixel.
// ----------------------------------------------------------------------------
module bssq_pos (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [bssq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bssq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_accept,
    input  logic [bssq_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_frame_start,
    output bssq_pkg::t_item                 o_item
);

    localparam int DIM_W  = bssq_pkg::DIM_W;
    localparam int WIN_W  = bssq_pkg::WIN_W;
    localparam int COL_W  = bssq_pkg::COL_W;
    localparam int ROW_W  = bssq_pkg::ROW_W;
    localparam int SLOT_W = bssq_pkg::SLOT_W;
    localparam int CNT_W  = bssq_pkg::CNT_W;

    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;
    logic [WIN_W-1:0]  r_window_size;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [WIN_W-1:0]  odd_s, eff_s;
    logic [CNT_W-1:0]  w, h, sw;
    logic [SLOT_W:0]   ss;
    logic [CNT_W-1:0]  c_t, r_t, cp1, rp1, left_t;
    logic [SLOT_W:0]   sl_t, sln;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic [SLOT_W-1:0] sl_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bssq_pkg::RST_IMAGE_WIDTH;
            r_image_height <= bssq_pkg::RST_IMAGE_HEIGHT;
            r_window_size  <= bssq_pkg::RST_WINDOW_SIZE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bssq_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                bssq_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                bssq_pkg::CFG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    always_comb begin
        eff_w = bssq_pkg::clamp_dim(r_image_width, DIM_W'(bssq_pkg::MAX_WIDTH));
        eff_h = bssq_pkg::clamp_dim(r_image_height, DIM_W'(bssq_pkg::MAX_HEIGHT));
        odd_s = r_window_size[0] ? r_window_size : r_window_size - WIN_W'(1);
        if (r_window_size < WIN_W'(3)) begin
            eff_s = WIN_W'(1);
        end else if (odd_s > WIN_W'(bssq_pkg::MAX_WINDOW)) begin
            eff_s = WIN_W'(bssq_pkg::MAX_WINDOW);
        end else begin
            eff_s = odd_s;
        end
        w  = CNT_W'(eff_w);
        h  = CNT_W'(eff_h);
        sw = CNT_W'(eff_s);
        ss = (SLOT_W+1)'(eff_s);

        // bring the position back into range
        c_t  = i_frame_start ? '0 : CNT_W'(r_col);
        r_t  = i_frame_start ? '0 : CNT_W'(r_row);
        sl_t = i_frame_start ? '0 : (SLOT_W+1)'(r_slot);
        if (c_t >= w) begin
            c_t  = '0;
            r_t  = r_t + CNT_W'(1);
            sl_t = sl_t + (SLOT_W+1)'(1);
        end
        if (r_t >= h) begin
            r_t  = '0;
            sl_t = '0;
        end
        if (sl_t >= ss) begin
            sl_t = '0;
        end
        c_cur  = c_t[COL_W-1:0];
        r_cur  = r_t[ROW_W-1:0];
        sl_cur = sl_t[SLOT_W-1:0];

        cp1    = CNT_W'(c_cur) + CNT_W'(1);
        rp1    = CNT_W'(r_cur) + CNT_W'(1);
        left_t = CNT_W'(c_cur) - sw;

        o_item.pixel     = i_pixel;
        o_item.first_row = (r_cur == '0);
        o_item.use_old   = (CNT_W'(r_cur) >= sw);
        o_item.row_start = (c_cur == '0);
        o_item.drop_left = (CNT_W'(c_cur) >= sw);
        o_item.result    = (cp1 >= sw) && (rp1 >= sw);
        o_item.out_col   = COL_W'(cp1 - sw);
        o_item.out_row   = ROW_W'(rp1 - sw);
        o_item.frame_end = (rp1 == h) && (cp1 == w);
        o_item.row_addr  = {sl_cur, c_cur};
        o_item.col_addr  = c_cur;
        o_item.left_addr = left_t[COL_W-1:0];

        // advance to the next pixel
        n_col  = cp1[COL_W-1:0];
        n_row  = r_cur;
        n_slot = sl_cur;
        if (cp1 >= w) begin
            n_col = '0;
            sln   = (SLOT_W+1)'(sl_cur) + (SLOT_W+1)'(1);
            if (sln >= ss) begin
                sln = '0;
            end
            if (rp1 >= h) begin
                n_row = '0;
                sln   = '0;
            end else begin
                n_row = rp1[ROW_W-1:0];
            end
            n_slot = sln[SLOT_W-1:0];
        end else begin
            sln = '0;
        end
    end

endmodule

// File: hdl/bssq_acc.sv
// ----------------------------------------------------------------------------
// bssq_acc
// Read-modify-write pipeline: column sum update with forwarding, running
// window sums along the row and the output register.
// ----------------------------------------------------------------------------
module bssq_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  bssq_pkg::t_item               i_item,
    input  logic [bssq_pkg::PIX_W-1:0]    i_row_q,
    input  logic [bssq_pkg::COLMEM_W-1:0] i_cola_q,
    input  logic [bssq_pkg::COLMEM_W-1:0] i_colb_q,
    input  logic                          i_out_stall,
    output logic                          o_in_stall,
    output bssq_pkg::t_wr                 o_wr,
    output bssq_pkg::t_pipe_stat          o_stat,
    output logic                          o_out_valid,
    output logic [bssq_pkg::SUM_W-1:0]    o_window_sum,
    output logic [bssq_pkg::SQS_W-1:0]    o_window_square_sum,
    output logic [bssq_pkg::COL_W-1:0]    o_out_col,
    output logic [bssq_pkg::ROW_W-1:0]    o_out_row,
    output logic                          o_frame_end
);

    localparam int PIX_W    = bssq_pkg::PIX_W;
    localparam int SQ_W     = bssq_pkg::SQ_W;
    localparam int CSUM_W   = bssq_pkg::CSUM_W;
    localparam int CSQ_W    = bssq_pkg::CSQ_W;
    localparam int SUM_W    = bssq_pkg::SUM_W;
    localparam int SQS_W    = bssq_pkg::SQS_W;
    localparam int COLMEM_W = bssq_pkg::COLMEM_W;
    localparam int COL_W    = bssq_pkg::COL_W;
    localparam int ROW_W    = bssq_pkg::ROW_W;

    logic                r_s1_v;
    bssq_pkg::t_item     r_s1;
    logic                r_s1_row_hit, r_s1_cola_hit, r_s1_colb_hit;
    logic [PIX_W-1:0]    r_s1_row_fwd;
    logic [COLMEM_W-1:0] r_s1_cola_fwd, r_s1_colb_fwd;

    logic                r_s2_v;
    bssq_pkg::t_item     r_s2;
    logic [PIX_W-1:0]    r_s2_oldp;
    logic [SQ_W-1:0]     r_s2_oldsq, r_s2_pixsq;
    logic [COLMEM_W-1:0] r_s2_cola, r_s2_colb;

    logic [SUM_W-1:0]    r_run_sum, n_run_sum;
    logic [SQS_W-1:0]    r_run_sq, n_run_sq;

    logic                r_s3_v;
    logic [SUM_W-1:0]    r_out_sum;
    logic [SQS_W-1:0]    r_out_sq;
    logic [COL_W-1:0]    r_out_col;
    logic [ROW_W-1:0]    r_out_row;
    logic                r_out_fe;

    logic                out_free, s2_adv, s2_free, s1_adv;
    logic [PIX_W-1:0]    row_e, row_p, oldp;
    logic [COLMEM_W-1:0] cola_e, cola_p, colb_e, colb_p;
    logic [CSUM_W-1:0]   new_sum;
    logic [CSQ_W-1:0]    new_sq;
    logic [SUM_W-1:0]    base_sum, left_sum;
    logic [SQS_W-1:0]    base_sq, left_sq;

    // flow control
    always_comb begin
        out_free   = !r_s3_v || !i_out_stall;
        s2_adv     = r_s2_v && (!r_s2.result || out_free);
        s2_free    = !r_s2_v || s2_adv;
        s1_adv     = r_s1_v && s2_free;
        o_in_stall = r_s1_v && !s1_adv;
    end

    // write back from stage 2
    always_comb begin
        o_wr.en       = s2_adv;
        o_wr.row_addr = r_s2.row_addr;
        o_wr.row_data = r_s2.pixel;
        o_wr.col_addr = r_s2.col_addr;
        o_wr.col_data = {new_sq, new_sum};
    end

    // read data with forwarding of writes that landed after the read
    always_comb begin
        row_e  = r_s1_row_hit  ? r_s1_row_fwd  : i_row_q;
        cola_e = r_s1_cola_hit ? r_s1_cola_fwd : i_cola_q;
        colb_e = r_s1_colb_hit ? r_s1_colb_fwd : i_colb_q;
        row_p  = (o_wr.en && o_wr.row_addr == r_s1.row_addr)  ? o_wr.row_data : row_e;
        cola_p = (o_wr.en && o_wr.col_addr == r_s1.col_addr)  ? o_wr.col_data : cola_e;
        colb_p = (o_wr.en && o_wr.col_addr == r_s1.left_addr) ? o_wr.col_data : colb_e;
        oldp   = r_s1.use_old ? row_p : '0;
    end

    // column and running sums
    always_comb begin
        if (r_s2.first_row) begin
            new_sum = CSUM_W'(r_s2.pixel);
            new_sq  = CSQ_W'(r_s2_pixsq);
        end else begin
            new_sum = r_s2_cola[CSUM_W-1:0] + CSUM_W'(r_s2.pixel) - CSUM_W'(r_s2_oldp);
            new_sq  = r_s2_cola[COLMEM_W-1:CSUM_W] + CSQ_W'(r_s2_pixsq)
                      - CSQ_W'(r_s2_oldsq);
        end
        base_sum  = r_s2.row_start ? '0 : r_run_sum;
        base_sq   = r_s2.row_start ? '0 : r_run_sq;
        left_sum  = r_s2.drop_left ? SUM_W'(r_s2_colb[CSUM_W-1:0]) : '0;
        left_sq   = r_s2.drop_left ? SQS_W'(r_s2_colb[COLMEM_W-1:CSUM_W]) : '0;
        n_run_sum = base_sum + SUM_W'(new_sum) - left_sum;
        n_run_sq  = base_sq + SQS_W'(new_sq) - left_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_run_sum <= '0;
            r_run_sq  <= '0;
        end else begin
            if (i_accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv && r_s2.result) begin
                r_s3_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_s3_v <= 1'b0;
            end
            if (s2_adv) begin
                r_run_sum <= n_run_sum;
                r_run_sq  <= n_run_sq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1          <= i_item;
            r_s1_row_hit  <= o_wr.en && (o_wr.row_addr == i_item.row_addr);
            r_s1_cola_hit <= o_wr.en && (o_wr.col_addr == i_item.col_addr);
            r_s1_colb_hit <= o_wr.en && (o_wr.col_addr == i_item.left_addr);
            r_s1_row_fwd  <= o_wr.row_data;
            r_s1_cola_fwd <= o_wr.col_data;
            r_s1_colb_fwd <= o_wr.col_data;
        end
        if (s1_adv) begin
            r_s2       <= r_s1;
            r_s2_oldp  <= oldp;
            r_s2_oldsq <= SQ_W'(oldp) * SQ_W'(oldp);
            r_s2_pixsq <= SQ_W'(r_s1.pixel) * SQ_W'(r_s1.pixel);
            r_s2_cola  <= cola_p;
            r_s2_colb  <= colb_p;
        end
        if (s2_adv && r_s2.result) begin
            r_out_sum <= n_run_sum;
            r_out_sq  <= n_run_sq;
            r_out_col <= r_s2.out_col;
            r_out_row <= r_s2.out_row;
            r_out_fe  <= r_s2.frame_end;
        end
    end

    assign o_stat.s1_v         = r_s1_v;
    assign o_stat.s2_v         = r_s2_v;
    assign o_out_valid         = r_s3_v;
    assign o_window_sum        = r_out_sum;
    assign o_window_square_sum = r_out_sq;
    assign o_out_col           = r_out_col;
    assign o_out_row           = r_out_row;
    assign o_frame_end         = r_out_fe;

endmodule

// File: hdl/box_sum_and_square_sum.sv
// ----------------------------------------------------------------------------
// box_sum_and_square_sum
// Sliding square window sum and sum of squares over a raster pixel stream.
// ----------------------------------------------------------------------------
// usage
//   pixels enter on i_pixel / i_frame_start with i_in_valid, held off by
//   o_in_stall; a request is taken when valid is high and stall is low
//   results leave on o_window_sum .. o_frame_end with o_out_valid, held off
//   by i_out_stall; one result per pixel that completes a full window
//   configuration writes go through i_cfg_valid / o_cfg_ready, index and data;
//   ready is always high, write only while the block is idle
//   throughput: one pixel per clock unless the receiver stalls, set by the single
//   read-modify-write pass over the column memory and the line store
//   a result passes the stage 1, stage 2 and output registers in turn
//   when the receiver stalls, the output register holds its result and the
//   pipeline keeps taking pixels until a second result would need the output
//   reset clears the pipeline, the raster position and the running sums and
//   loads width 1024, height 1024, window 3; the memories are not cleared
// ----------------------------------------------------------------------------
`include "box_sum_and_square_sum_macros.svh"

module box_sum_and_square_sum (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bssq_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_frame_start,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bssq_pkg::SUM_W-1:0]      o_window_sum,
    output logic [bssq_pkg::SQS_W-1:0]      o_window_square_sum,
    output logic [bssq_pkg::COL_W-1:0]      o_out_col,
    output logic [bssq_pkg::ROW_W-1:0]      o_out_row,
    output logic                            o_frame_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bssq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bssq_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                          w_accept;
    bssq_pkg::t_item               w_item;
    bssq_pkg::t_wr                 w_wr;
    bssq_pkg::t_pipe_stat          w_stat;
    logic [bssq_pkg::PIX_W-1:0]    w_row_q;
    logic [bssq_pkg::COLMEM_W-1:0] w_cola_q, w_colb_q;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;

    bssq_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (w_accept),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_item        (w_item)
    );

    // line store of the last window rows
    bssq_ram #(
        .WIDTH (bssq_pkg::PIX_W),
        .DEPTH (bssq_pkg::ROWBUF_DEPTH)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr.en),
        .i_wr_addr (w_wr.row_addr),
        .i_wr_data (w_wr.row_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_item.row_addr),
        .o_rd_data (w_row_q)
    );

    // column sums, current column
    bssq_ram #(
        .WIDTH (bssq_pkg::COLMEM_W),
        .DEPTH (bssq_pkg::MAX_WIDTH)
    ) u_cola_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr.en),
        .i_wr_addr (w_wr.col_addr),
        .i_wr_data (w_wr.col_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_item.col_addr),
        .o_rd_data (w_cola_q)
    );

    // column sums copy, column leaving the window
    bssq_ram #(
        .WIDTH (bssq_pkg::COLMEM_W),
        .DEPTH (bssq_pkg::MAX_WIDTH)
    ) u_colb_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr.en),
        .i_wr_addr (w_wr.col_addr),
        .i_wr_data (w_wr.col_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_item.left_addr),
        .o_rd_data (w_colb_q)
    );

    bssq_acc u_acc (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (w_accept),
        .i_item              (w_item),
        .i_row_q             (w_row_q),
        .i_cola_q            (w_cola_q),
        .i_colb_q            (w_colb_q),
        .i_out_stall         (i_out_stall),
        .o_in_stall          (o_in_stall),
        .o_wr                (w_wr),
        .o_stat              (w_stat),
        .o_out_valid         (o_out_valid),
        .o_window_sum        (o_window_sum),
        .o_window_square_sum (o_window_square_sum),
        .o_out_col           (o_out_col),
        .o_out_row           (o_out_row),
        .o_frame_end         (o_frame_end)
    );

    `BSSQ_ASSERT_IMPLIES(a_stall_source, o_in_stall, o_out_valid && i_out_stall)
    `BSSQ_ASSERT_NEXT(a_accept_fills, w_accept, w_stat.s1_v)
    `BSSQ_ASSERT_NEXT(a_out_drain, o_out_valid && !i_out_stall && !w_stat.s2_v, !o_out_valid)

endmodule
